// ===== hdl/ils_pkg.sv =====
package ils_pkg;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_ZERO   = 2'd1,
    PH_DIGITS = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_HEX = 2'd1,
    RADIX_BIN = 2'd2,
    RADIX_OCT = 2'd3
  } radix_t;

  localparam int unsigned ValueWidth = 64;
  localparam int unsigned ProdWidth  = ValueWidth + 4;

  localparam logic [4:0] NOT_DIGIT = 5'd16;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_LO_B  = 8'h62;
  localparam logic [7:0] CH_UP_B  = 8'h42;

  // digit value 0..15, or NOT_DIGIT for a terminator
  function automatic logic [4:0] digit_value(input logic [7:0] c);
    logic [7:0] t;
    begin
      t = 8'd0;
      if (c >= CH_0 && c <= CH_9) begin
        t = c - CH_0;
      end else if (c >= CH_LO_A && c <= CH_LO_F) begin
        t = c - CH_LO_A + 8'd10;
      end else if (c >= CH_UP_A && c <= CH_UP_F) begin
        t = c - CH_UP_A + 8'd10;
      end else begin
        t = {3'd0, NOT_DIGIT};
      end
      return t[4:0];
    end
  endfunction

endpackage

// ===== hdl/ils_if.sv =====
interface ils_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       start_req;

  modport source (output valid, output ch, output start_req, input ready);
  modport sink   (input valid, input ch, input start_req, output ready);
endinterface

interface ils_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] lit_value;
  logic [1:0]  radix;
  logic        digit_error;
  logic        overflow;

  modport source (output valid, output lit_value, output radix, output digit_error,
                  output overflow, input ready);
  modport sink   (input valid, input lit_value, input radix, input digit_error,
                  input overflow, output ready);
endinterface

// ===== hdl/integer_literal_scanner_core.sv =====
// Integer literal scanner: takes one source byte per request and sustains one byte per
// cycle. A byte is first captured in an input register, then the scan state (phase,
// accumulator, radix, flags) is updated by one multiply-by-base (shifts and adds) and a
// finished literal lands in the result register, so a terminating byte passes the input
// register and then the result register before its result is valid. While a result waits
// untaken, the byte in the input register is held and the input stalls; when each result
// is taken at once, bytes flow back to back with no gap.
module integer_literal_scanner_core (
  input  logic clk,
  input  logic rst_n,
  ils_in_if.sink    in_chan,
  ils_out_if.source out_chan
);

  // input register
  logic       in_valid_r;
  logic [7:0] ch_r;
  logic       start_r;

  // scan state
  ils_pkg::phase_t phase_r, phase_nxt;
  logic [63:0]     accum_r, accum_nxt;
  ils_pkg::radix_t radix_r, radix_nxt;
  logic            bad_r, bad_nxt;
  logic            ovf_r, ovf_nxt;

  // result register
  logic            out_valid_r, out_valid_nxt;
  logic [63:0]     out_value_r;
  ils_pkg::radix_t out_radix_r;
  logic            out_bad_r;
  logic            out_ovf_r;

  logic            advance;
  logic            emit;
  logic [4:0]      dig;
  logic            is_digit;
  logic            is_dec;

  // absorb datapath
  logic            do_absorb;
  logic [63:0]     a_acc;
  ils_pkg::radix_t a_rad;
  logic            a_bad;
  logic            a_ovf;
  logic            out_of_range;
  logic [3:0]      dv;
  logic [ils_pkg::ProdWidth-1:0] acc_ext;
  logic [ils_pkg::ProdWidth-1:0] prod;
  logic [ils_pkg::ProdWidth-1:0] sum;

  assign advance       = !out_valid_r || out_chan.ready;
  assign in_chan.ready = !in_valid_r || advance;

  assign dig      = ils_pkg::digit_value(ch_r);
  assign is_digit = (dig != ils_pkg::NOT_DIGIT);
  assign is_dec   = (ch_r >= ils_pkg::CH_0) && (ch_r <= ils_pkg::CH_9);

  // control: which path this byte takes and what feeds the accumulator
  always_comb begin
    phase_nxt = phase_r;
    radix_nxt = radix_r;
    emit      = 1'b0;
    do_absorb = 1'b0;
    a_acc     = accum_r;
    a_rad     = radix_r;
    a_bad     = bad_r;
    a_ovf     = ovf_r;
    if (in_valid_r && advance) begin
      unique case (phase_r)
        ils_pkg::PH_ZERO: begin
          phase_nxt = ils_pkg::PH_DIGITS;
          if (ch_r == ils_pkg::CH_LO_X || ch_r == ils_pkg::CH_UP_X) begin
            radix_nxt = ils_pkg::RADIX_HEX;
          end else if (ch_r == ils_pkg::CH_LO_B || ch_r == ils_pkg::CH_UP_B) begin
            radix_nxt = ils_pkg::RADIX_BIN;
          end else begin
            // the byte after the leading zero is also a digit or the end
            if (is_dec) begin
              radix_nxt = ils_pkg::RADIX_OCT;
              a_rad     = ils_pkg::RADIX_OCT;
            end
            if (is_digit) begin
              do_absorb = 1'b1;
            end else begin
              emit      = 1'b1;
              phase_nxt = ils_pkg::PH_IDLE;
            end
          end
        end
        ils_pkg::PH_DIGITS: begin
          if (is_digit) begin
            do_absorb = 1'b1;
          end else begin
            emit      = 1'b1;
            phase_nxt = ils_pkg::PH_IDLE;
          end
        end
        default: begin
          phase_nxt = ils_pkg::PH_IDLE;
          if (start_r && is_digit) begin
            radix_nxt = ils_pkg::RADIX_DEC;
            a_acc     = '0;
            a_rad     = ils_pkg::RADIX_DEC;
            a_bad     = 1'b0;
            a_ovf     = 1'b0;
            if (ch_r == ils_pkg::CH_0) begin
              phase_nxt = ils_pkg::PH_ZERO;
            end else begin
              phase_nxt = ils_pkg::PH_DIGITS;
              do_absorb = 1'b1;
            end
          end
        end
      endcase
    end
  end

  // value = value * base + digit, overflow when the top bits are set
  always_comb begin
    acc_ext = {4'd0, a_acc};
    unique case (a_rad)
      ils_pkg::RADIX_HEX: begin
        out_of_range = 1'b0;
        prod         = acc_ext << 4;
      end
      ils_pkg::RADIX_BIN: begin
        out_of_range = (dig > 5'd1);
        prod         = acc_ext << 1;
      end
      ils_pkg::RADIX_OCT: begin
        out_of_range = (dig > 5'd7);
        prod         = acc_ext << 3;
      end
      default: begin
        out_of_range = (dig > 5'd9);
        prod         = (acc_ext << 3) + (acc_ext << 1);
      end
    endcase
    dv  = out_of_range ? 4'd0 : dig[3:0];
    sum = prod + {{(ils_pkg::ProdWidth-4){1'b0}}, dv};

    accum_nxt = a_acc;
    bad_nxt   = a_bad;
    ovf_nxt   = a_ovf;
    if (do_absorb && !a_ovf) begin
      bad_nxt = a_bad | out_of_range;
      if (sum[ils_pkg::ProdWidth-1:ils_pkg::ValueWidth] != 4'd0) begin
        ovf_nxt   = 1'b1;
        accum_nxt = '0;
      end else begin
        accum_nxt = sum[ils_pkg::ValueWidth-1:0];
      end
    end
  end

  assign out_valid_nxt = advance ? (in_valid_r && emit) : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= ils_pkg::PH_IDLE;
      accum_r     <= '0;
      radix_r     <= ils_pkg::RADIX_DEC;
      bad_r       <= 1'b0;
      ovf_r       <= 1'b0;
    end else begin
      if (in_chan.ready) begin
        in_valid_r <= in_chan.valid;
      end
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
      accum_r     <= accum_nxt;
      radix_r     <= radix_nxt;
      bad_r       <= bad_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready) begin
      ch_r    <= in_chan.ch;
      start_r <= in_chan.start_req;
    end
    if (advance) begin
      out_value_r <= accum_r;
      out_radix_r <= radix_r;
      out_bad_r   <= bad_r;
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.lit_value   = out_value_r;
  assign out_chan.radix       = out_radix_r;
  assign out_chan.digit_error = out_bad_r;
  assign out_chan.overflow    = out_ovf_r;

endmodule
